>>> rtl/nbbr_pkg.sv
// Nine-bit block receiver: shared types and constants.
// Holds the item structs and the frame status codes; no dependencies.
package nbbr_pkg;

  localparam int unsigned CharW  = 9;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 6;
  localparam int unsigned IdleW  = 17;
  localparam int unsigned LimitW = 16;

  localparam logic [LimitW-1:0] TimeoutReset = 16'd1000;

  // Request kinds on the input channel.
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_IDLE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_CHKSUM  = 2'd2,
    ST_OVERLEN = 2'd3
  } frame_status_e;

  typedef struct packed {
    logic             req_type;
    logic [CharW-1:0] rx_char;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic [CountW-1:0] byte_index;
    logic              has_byte;
    frame_status_e     frame_status;
    logic [CountW-1:0] frame_length;
    logic              last;
  } out_item_t;

endpackage

>>> rtl/nine_bit_block_receiver_unit.sv
// Nine-bit block receiver top level: frame assembly, checksum and drain.
// Depends on nbbr_pkg and nbbr_ram.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_item_i): one item per bus
//    character or idle tick. Items that do not end a frame are taken one per
//    cycle while no drain is under way and give no result.
//  - Output channel (out_valid_o / out_stall_i / out_item_o): at frame end the
//    stored bytes come out in order, each with status and length, the final
//    one marked last; a frame with no bytes gives one byteless item.
//  - Drain: after the item that ends the frame, each stored byte goes through
//    a RAM read, then a load of the output register, one byte at a time; an
//    empty frame needs only the load of its byteless item. The input stalls
//    for the whole drain.
//  - The timeout register is written through cfg_we_i / cfg_wdata_i; the
//    user must write it only while the block is idle, as the block itself
//    does not enforce that. It resets to 1000 ticks.
//  - Reset clears the counters, the running sum and the output valid; the
//    byte store is not cleared, as only bytes of the current frame are read.
//  - A stalled output holds its item; the drain waits until it is taken.
module nine_bit_block_receiver_unit #(
  parameter int unsigned BLOCK_LIMIT = 36
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  nbbr_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output nbbr_pkg::out_item_t  out_item_o
);

  import nbbr_pkg::*;

  localparam int unsigned Depth = BLOCK_LIMIT + 1;
  localparam int unsigned AddrW = $clog2(Depth);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_EMPTY
  } state_e;

  state_e              state_q;
  logic [LimitW-1:0]   timeout_q;
  logic [CountW-1:0]   byte_cnt_q;
  logic [ByteW-1:0]    sum_q;
  logic [IdleW-1:0]    idle_q;
  logic [CountW-1:0]   len_q;
  frame_status_e       status_q;
  logic [CountW-1:0]   rd_idx_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic [IdleW-1:0]    idle_inc;
  logic [CountW-1:0]   cnt_inc;
  logic [ByteW-1:0]    rx_byte;
  logic                end_frame;
  logic [CountW-1:0]   end_len;
  frame_status_e       end_status;
  logic                ram_we;
  logic [ByteW-1:0]    ram_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = out_free && (state_q == S_LOAD || state_q == S_EMPTY);

  assign idle_inc = idle_q + IdleW'(1);
  assign cnt_inc  = byte_cnt_q + CountW'(1);
  assign rx_byte  = in_item_i.rx_char[ByteW-1:0];

  // Decide whether the accepted item closes the frame, and with what.
  always_comb begin
    end_frame  = 1'b0;
    end_len    = byte_cnt_q;
    end_status = ST_TIMEOUT;
    ram_we     = 1'b0;
    if (in_acc) begin
      if (in_item_i.req_type == REQ_IDLE) begin
        if (idle_inc > {1'b0, timeout_q}) begin
          end_frame = 1'b1;
        end
      end else begin
        ram_we = 1'b1;
        if (in_item_i.rx_char[ByteW]) begin
          end_frame = 1'b1;
          if (cnt_inc == CountW'(1)) begin
            end_len    = cnt_inc;
            end_status = ST_OK;
          end else if (rx_byte != sum_q) begin
            // Keep the checksum byte on a mismatch.
            end_len    = cnt_inc;
            end_status = ST_CHKSUM;
          end else begin
            // Drop the checksum byte on a match.
            end_len    = cnt_inc - CountW'(1);
            end_status = ST_OK;
          end
        end else if (cnt_inc > CountW'(BLOCK_LIMIT)) begin
          end_frame  = 1'b1;
          end_len    = cnt_inc;
          end_status = ST_OVERLEN;
        end
      end
    end
  end

  nbbr_ram #(
    .WIDTH (ByteW),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (byte_cnt_q[AddrW-1:0]),
    .wdata_i (rx_byte),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      timeout_q   <= TimeoutReset;
      byte_cnt_q  <= '0;
      sum_q       <= '0;
      idle_q      <= '0;
      len_q       <= '0;
      status_q    <= ST_OK;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      // Raise valid on a new load, else drop the output item once taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (end_frame) begin
              byte_cnt_q <= '0;
              sum_q      <= '0;
              idle_q     <= '0;
              len_q      <= end_len;
              status_q   <= end_status;
              rd_idx_q   <= '0;
              state_q    <= (end_len == '0) ? S_EMPTY : S_READ;
            end else if (in_item_i.req_type == REQ_IDLE) begin
              idle_q <= idle_inc;
            end else begin
              idle_q     <= '0;
              byte_cnt_q <= cnt_inc;
              sum_q      <= sum_q + rx_byte;
            end
          end
        end
        S_READ: begin
          // Read address is presented; data is registered by the next cycle.
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            out_q.data_byte    <= ram_rdata;
            out_q.byte_index   <= rd_idx_q;
            out_q.has_byte     <= 1'b1;
            out_q.frame_status <= status_q;
            out_q.frame_length <= len_q;
            out_q.last         <= (rd_idx_q == len_q - CountW'(1));
            if (rd_idx_q == len_q - CountW'(1)) begin
              state_q <= S_IDLE;
            end else begin
              rd_idx_q <= rd_idx_q + CountW'(1);
              state_q  <= S_READ;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_q.data_byte    <= '0;
            out_q.byte_index   <= '0;
            out_q.has_byte     <= 1'b0;
            out_q.frame_status <= status_q;
            out_q.frame_length <= '0;
            out_q.last         <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  // A byteless item is always the single, final item of an empty frame.
  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.has_byte) |->
      (out_item_o.last && out_item_o.frame_length == '0))
    else $error("byteless item not marked as empty frame end");

  // The stored count never passes the block limit between frames.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_cnt_q <= CountW'(BLOCK_LIMIT)))
    else $error("byte count beyond block limit");

  // The drain index stays inside the frame being delivered.
  a_drain_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_LOAD) |-> (rd_idx_q < len_q))
    else $error("drain index outside frame");

  // A frame end clears the counters for the next frame.
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_frame) |=> (byte_cnt_q == '0 && sum_q == '0 && idle_q == '0))
    else $error("counters not cleared at frame end");
`endif

endmodule

>>> rtl/nbbr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the frame byte store.
module nbbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 37
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for nine_bit_block_receiver_unit.
// Predicts each finished frame from the items it accepts and checks every result item.
// Depends on nbbr_pkg and the block's RTL only.
module testbench;
  import nbbr_pkg::*;

  localparam int unsigned BlockLimit = 36;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Ports of the block; the driven inputs are all known from time zero
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  nine_bit_block_receiver_unit #(
    .BLOCK_LIMIT(BlockLimit)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Own copy of the receiver state: byte store, count, sum, idle ticks and timeout.
  logic [ByteW-1:0]  frame_bytes [BlockLimit+1];
  int unsigned       frame_count  = 0;
  logic [ByteW-1:0]  frame_sum    = '0;
  logic [IdleW-1:0]  idle_ticks   = '0;
  logic [LimitW-1:0] timeout_ticks = TimeoutReset;

  // Result items still owed by the block, oldest first
  out_item_t expected_bytes [$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;

  // Sender pacing: burst length left, and a switch that removes gaps for long idle runs
  int unsigned burst_left = 0;
  bit          steady     = 1'b0;

  // Receiver pacing
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned stall_mode = 0;
  logic [31:0] stall_tick = '0;

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  // Queue every stored byte of the frame with its status, or one byteless item
  // for an empty frame; then clear the counters for the next frame.
  function automatic void deliver_frame(int unsigned len, frame_status_e status);
    out_item_t   r;
    int unsigned k;
    if (len == 0) begin
      r              = '0;
      r.frame_status = status;
      r.last         = 1'b1;
      expected_bytes.push_back(r);
    end else begin
      for (k = 0; k < len; k++) begin
        r.data_byte    = frame_bytes[k];
        r.byte_index   = CountW'(k);
        r.has_byte     = 1'b1;
        r.frame_status = status;
        r.frame_length = CountW'(len);
        r.last         = (k + 1 == len);
        expected_bytes.push_back(r);
      end
    end
    frame_count = 0;
    frame_sum   = '0;
    idle_ticks  = '0;
  endfunction

  // Advance the predicted state by one accepted item.
  function automatic void assemble_frame(in_item_t it);
    logic [ByteW-1:0] b;
    b = it.rx_char[ByteW-1:0];
    if (it.req_type == REQ_IDLE) begin
      // A poll with no character: count it; time out once past the limit
      idle_ticks = idle_ticks + 1'b1;
      if (idle_ticks > {1'b0, timeout_ticks}) deliver_frame(frame_count, ST_TIMEOUT);
      return;
    end
    idle_ticks               = '0;
    frame_bytes[frame_count] = b;
    frame_count++;
    if (it.rx_char[CharW-1]) begin
      // Last character: a lone byte is a whole block; otherwise it is the checksum
      if (frame_count == 1)   deliver_frame(1, ST_OK);
      else if (b != frame_sum) deliver_frame(frame_count, ST_CHKSUM);
      else                     deliver_frame(frame_count - 1, ST_OK);
    end else if (frame_count > BlockLimit) begin
      // Too many data characters: deliver all of them, the extra one too
      deliver_frame(frame_count, ST_OVERLEN);
    end else begin
      frame_sum = frame_sum + b;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Compare each accepted result item with the oldest one owed.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("result item with none owed", 32'(out_item_o), 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_item_o.data_byte != want.data_byte)
          report_mismatch("data_byte", out_item_o.data_byte, want.data_byte);
        if (out_item_o.byte_index != want.byte_index)
          report_mismatch("byte_index", out_item_o.byte_index, want.byte_index);
        if (out_item_o.has_byte != want.has_byte)
          report_mismatch("has_byte", out_item_o.has_byte, want.has_byte);
        if (out_item_o.frame_status != want.frame_status)
          report_mismatch("frame_status", out_item_o.frame_status, want.frame_status);
        if (out_item_o.frame_length != want.frame_length)
          report_mismatch("frame_length", out_item_o.frame_length, want.frame_length);
        if (out_item_o.last != want.last)
          report_mismatch("last", out_item_o.last, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern
  // ---------------------------------------------------------------------------

  // Switch the stall mode when the low bits of the tick counter are all zero; a hold
  // request overrides the mode with a long unbroken stall, counted here.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end
    if (stall_tick[6:0] == 7'd0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall_i <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall_i <= stall_tick[2];
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  function automatic in_item_t char_item(logic [CharW-1:0] c);
    in_item_t it;
    it.req_type = REQ_CHAR;
    it.rx_char  = c;
    return it;
  endfunction

  // Offer one item, hold it until taken, then predict. Valid stays high after
  // acceptance, so the caller must send again or drain within the same step.
  task automatic send_item(in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    assemble_frame(it);
    items_sent++;
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // End the burst: drop valid for a random gap, then pick the next burst length
        burst_left = $urandom_range(0, 30);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  // Idle ticks with random (ignored) character content
  task automatic send_idles(int unsigned n);
    in_item_t it;
    repeat (n) begin
      it.req_type = REQ_IDLE;
      it.rx_char  = 9'($urandom_range(0, 511));
      send_item(it);
    end
  endtask

  // A block of n characters whose last one carries the checksum, right or wrong,
  // with short idle runs between characters that stay within the timeout.
  task automatic send_block(int unsigned n, bit bad_sum);
    int unsigned k;
    int unsigned idle_max;
    logic [ByteW-1:0] flip;
    idle_max = (timeout_ticks > 4) ? 4 : timeout_ticks;
    for (k = 1; k < n; k++) begin
      send_item(char_item({1'b0, 8'($urandom_range(0, 255))}));
      if (idle_max > 0 && $urandom_range(0, 3) == 0) send_idles($urandom_range(1, idle_max));
    end
    flip = bad_sum ? 8'($urandom_range(1, 255)) : 8'h00;
    send_item(char_item({1'b1, frame_sum ^ flip}));
  endtask

  // Stop offering and wait until every owed result has been taken, then let the
  // block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Write the timeout register with the block idle.
  task automatic set_timeout(logic [LimitW-1:0] ticks);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    timeout_ticks = ticks;
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked blocks: single characters, checksum match and mismatch, sum
  // wrap, then the empty frame and a one-byte timeout at a zero limit.
  task automatic test_directed();
    send_item(char_item(9'h100));
    send_item(char_item(9'h1ff));
    send_item(char_item(9'h012));
    send_item(char_item(9'h034));
    send_item(char_item(9'h146));
    send_item(char_item(9'h0ff));
    send_item(char_item(9'h001));
    send_item(char_item(9'h1ff));
    send_item(char_item(9'h0ff));
    send_item(char_item(9'h002));
    send_item(char_item(9'h101));
    send_item(char_item(9'h000));
    send_item(char_item(9'h100));
    set_timeout(16'd0);
    send_idles(1);
    send_item(char_item(9'h055));
    send_idles(1);
    send_item(char_item(9'h0aa));
    send_item(char_item(9'h1aa));
    wait_drained();
  endtask

  // Default limit: idle runs between characters do not end the frame, and the
  // block closes on its checksum.
  task automatic test_default_timeout();
    steady = 1'b1;
    send_item(char_item(9'h0c3));
    send_idles(10);
    send_item(char_item(9'h03c));
    send_idles(10);
    send_item(char_item({1'b1, frame_sum}));
    steady = 1'b0;
    wait_drained();
  endtask

  // Largest limit: an idle run leaves the frame open until its checksum.
  task automatic test_max_timeout();
    set_timeout(16'hffff);
    steady = 1'b1;
    send_item(char_item(9'h0ab));
    send_idles(20);
    send_item(char_item({1'b1, frame_sum}));
    steady = 1'b0;
    wait_drained();
  endtask

  // Too many data characters, and the longest blocks with good and bad checksums.
  task automatic test_overlength();
    set_timeout(16'd20);
    repeat (BlockLimit + 1) send_item(char_item({1'b0, 8'($urandom_range(0, 255))}));
    send_block(BlockLimit + 1, 1'b0);
    send_block(BlockLimit + 1, 1'b1);
    wait_drained();
  endtask

  // Hold the output off for a long stretch while blocks keep coming, so the
  // drain backs up and the input stalls.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (4) send_block($urandom_range(8, 20), 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  // Mostly well-formed blocks with random content, plus broken blocks,
  // overlength runs, timeouts and random noise, over several timeout settings.
  task automatic test_random();
    logic [LimitW-1:0] limits [4];
    int unsigned       p;
    int unsigned       kind;
    int unsigned       phase_end;
    limits[0] = 16'd0;
    limits[1] = 16'($urandom_range(1, 3));
    limits[2] = 16'($urandom_range(4, 20));
    limits[3] = 16'hffff;
    for (p = 0; p < 4; p++) begin
      set_timeout(limits[p]);
      phase_end = items_sent + 25;
      while (items_sent < phase_end) begin
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          send_block(($urandom_range(0, 4) != 0) ? $urandom_range(1, 8)
                                                 : $urandom_range(9, BlockLimit + 1), 1'b0);
        end else if (kind < 70) begin
          send_block($urandom_range(2, 12), 1'b1);
        end else if (kind < 76) begin
          repeat (BlockLimit + 1) send_item(char_item({1'b0, 8'($urandom_range(0, 255))}));
        end else if (kind < 88 && timeout_ticks <= 20) begin
          // Time out a partly built frame, or an empty one
          repeat ($urandom_range(0, 4)) send_item(char_item({1'b0, 8'($urandom_range(0, 255))}));
          send_idles(timeout_ticks + 1);
        end else begin
          repeat ($urandom_range(1, 5)) begin
            in_item_t it;
            it.req_type = 1'($urandom_range(0, 1));
            it.rx_char  = 9'($urandom_range(0, 511));
            send_item(it);
          end
        end
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_timeout(TimeoutReset);
    test_default_timeout();
    test_max_timeout();
    test_overlength();
    test_backpressure();
    test_random();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
